@@ src/trq_pkg.sv @@
package trq_pkg;

  localparam int THREADS     = 16;
  localparam int QUANTA_BITS = 16;
  localparam int IDX_W       = $clog2(THREADS);
  localparam int LEN_W       = $clog2(THREADS + 1);
  localparam int ID_W        = 4;
  localparam int OP_W        = 3;
  localparam int ST_W        = 3;
  localparam int SQ_W        = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_READY = 3'd0,
    OP_POP_READY = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_ADD_SLEEP = 3'd3,
    OP_DECREMENT = 3'd4,
    OP_WAKE      = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_t;

  // per-cell control: take neighbour's id, or load the incoming id
  typedef struct packed {
    logic sh;
    logic ld;
  } cell_ctl_t;

  // list command from the sequencer
  typedef struct packed {
    logic             push;
    logic             del_first;
    logic             del_at;
    logic [IDX_W-1:0] pos;
    logic [ID_W-1:0]  val;
  } list_ctl_t;

endpackage

@@ src/trq_cell.sv @@
module trq_cell (
  input  logic                     clk,
  input  trq_pkg::cell_ctl_t       ctl,
  input  logic [trq_pkg::ID_W-1:0] val,
  input  logic [trq_pkg::ID_W-1:0] nbr,
  output logic [trq_pkg::ID_W-1:0] id_q
);

  logic [trq_pkg::ID_W-1:0] id_r;
  logic [trq_pkg::ID_W-1:0] id_nxt;

  always_comb begin
    id_nxt = id_r;
    if (ctl.sh) begin
      id_nxt = nbr;
    end else if (ctl.ld) begin
      id_nxt = val;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign id_q = id_r;

endmodule

@@ src/trq_list.sv @@
module trq_list (
  input  logic                      clk,
  input  logic                      rst_n,
  input  trq_pkg::list_ctl_t        ctl,
  output logic [trq_pkg::ID_W-1:0]  ids [trq_pkg::THREADS],
  output logic [trq_pkg::LEN_W-1:0] len,
  output logic                      hit
);

  logic [trq_pkg::LEN_W-1:0]   len_r;
  logic [trq_pkg::LEN_W-1:0]   len_nxt;
  logic [trq_pkg::THREADS-1:0] match;
  logic [trq_pkg::THREADS-1:0] first;
  logic [trq_pkg::THREADS-1:0] sel;
  logic [trq_pkg::THREADS-1:0] ge;
  trq_pkg::cell_ctl_t          cctl [trq_pkg::THREADS];

  // oldest match only, lowest live index
  always_comb begin
    for (int i = 0; i < trq_pkg::THREADS; i++) begin
      match[i] = (ids[i] == ctl.val) && (trq_pkg::LEN_W'(i) < len_r);
    end
    first = match & (~match + trq_pkg::THREADS'(1));
    sel   = '0;
    if (ctl.del_first) begin
      sel = first;
    end else if (ctl.del_at) begin
      sel = trq_pkg::THREADS'(1) << ctl.pos;
    end
    ge = (sel != '0) ? ~(sel - trq_pkg::THREADS'(1)) : '0;
    for (int i = 0; i < trq_pkg::THREADS; i++) begin
      cctl[i].sh = ge[i];
      cctl[i].ld = ctl.push && (trq_pkg::LEN_W'(i) == len_r);
    end
    len_nxt = len_r;
    if (sel != '0) begin
      len_nxt = len_r - trq_pkg::LEN_W'(1);
    end else if (ctl.push) begin
      len_nxt = len_r + trq_pkg::LEN_W'(1);
    end
  end

  for (genvar g = 0; g < trq_pkg::THREADS; g++) begin : g_cell
    logic [trq_pkg::ID_W-1:0] nbr;
    if (g == trq_pkg::THREADS - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = ids[g+1];
    end
    trq_cell u_cell (
      .clk  (clk),
      .ctl  (cctl[g]),
      .val  (ctl.val),
      .nbr  (nbr),
      .id_q (ids[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  assign len = len_r;
  assign hit = |match;

endmodule

@@ src/thread_ready_queue_with_sleep_timers_core.sv @@
// channel | dir | tdata fields, lowest bit first
// in_     | in  | operation[2:0] thread_id[6:3] sleep_quanta[22:7], pad to 24
// out_    | out | status[2:0] popped_id[6:3] ready_count[11:7]
//         |     | sleeper_count[16:12], pad to 24
// sequencing: one operation at a time; a simple operation passes through accept,
// execute and result register; decrement and wake walk the sleeper cells one
// entry a cycle between execute and the result register
// reset: rst_n synchronous, empties both lists; counts need no clearing
// stalls: input waits while busy; a held result stalls only the next result
module thread_ready_queue_with_sleep_timers_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // operation, thread_id, sleep_quanta
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // status, popped_id, ready_count, sleeper_count
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DEC, S_WAKE, S_OUT} state_t;

  state_t                         state_r, state_nxt;
  logic [trq_pkg::OP_W-1:0]       op_r, op_nxt;
  logic [trq_pkg::ID_W-1:0]       id_r, id_nxt;
  logic [trq_pkg::QUANTA_BITS-1:0] q_r, q_nxt;
  logic [trq_pkg::IDX_W-1:0]      k_r, k_nxt;
  trq_pkg::status_t               st_r, st_nxt;
  logic [trq_pkg::ID_W-1:0]       pop_r, pop_nxt;
  logic                           ov_r, ov_nxt;
  logic [23:0]                    od_r, od_nxt;

  // per-thread countdowns, indexed by id
  logic [trq_pkg::QUANTA_BITS-1:0] cnt_r [trq_pkg::THREADS];
  logic                            cnt_we;
  logic [trq_pkg::IDX_W-1:0]       cnt_wa;
  logic [trq_pkg::QUANTA_BITS-1:0] cnt_wd;

  trq_pkg::list_ctl_t         rctl, sctl;
  logic [trq_pkg::ID_W-1:0]   rids [trq_pkg::THREADS];
  logic [trq_pkg::ID_W-1:0]   sids [trq_pkg::THREADS];
  logic [trq_pkg::LEN_W-1:0]  rlen, slen;
  logic                       rhit, shit;

  logic                            id_ok;
  logic [trq_pkg::ID_W-1:0]        kid;
  logic [trq_pkg::QUANTA_BITS-1:0] kcnt;

  trq_list u_ready (
    .clk (clk), .rst_n (rst_n), .ctl (rctl), .ids (rids), .len (rlen), .hit (rhit)
  );
  trq_list u_sleep (
    .clk (clk), .rst_n (rst_n), .ctl (sctl), .ids (sids), .len (slen), .hit (shit)
  );

  assign id_ok = 32'(id_r) < trq_pkg::THREADS;
  assign kid   = sids[k_r];
  assign kcnt  = cnt_r[trq_pkg::IDX_W'(kid)];

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    id_nxt    = id_r;
    q_nxt     = q_r;
    k_nxt     = k_r;
    st_nxt    = st_r;
    pop_nxt   = pop_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    cnt_we    = 1'b0;
    cnt_wa    = trq_pkg::IDX_W'(id_r);
    cnt_wd    = q_r;
    rctl      = '{push: 1'b0, del_first: 1'b0, del_at: 1'b0, pos: '0, val: id_r};
    sctl      = '{push: 1'b0, del_first: 1'b0, del_at: 1'b0, pos: '0, val: id_r};

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tdata[2:0];
          id_nxt    = in_tdata[6:3];
          q_nxt     = trq_pkg::QUANTA_BITS'(in_tdata[22:7]);
          st_nxt    = trq_pkg::ST_OK;
          pop_nxt   = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        unique case (op_r)
          trq_pkg::OP_ADD_READY: begin
            if (!id_ok) begin
              st_nxt = trq_pkg::ST_NOT_FOUND;
            end else if (32'(rlen) >= trq_pkg::THREADS) begin
              st_nxt = trq_pkg::ST_FULL;
            end else begin
              rctl.push = 1'b1;
            end
          end
          trq_pkg::OP_POP_READY: begin
            if (rlen == '0) begin
              st_nxt = trq_pkg::ST_EMPTY;
            end else begin
              pop_nxt     = rids[0];
              rctl.del_at = 1'b1;
            end
          end
          trq_pkg::OP_REMOVE: begin
            if (!id_ok) begin
              st_nxt = trq_pkg::ST_NOT_FOUND;
            end else begin
              rctl.del_first = 1'b1;
              sctl.del_first = 1'b1;
              if (!rhit && !shit) st_nxt = trq_pkg::ST_NOT_FOUND;
            end
          end
          trq_pkg::OP_ADD_SLEEP: begin
            if (!id_ok) begin
              st_nxt = trq_pkg::ST_NOT_FOUND;
            end else if (32'(slen) >= trq_pkg::THREADS) begin
              st_nxt = trq_pkg::ST_FULL;
            end else begin
              cnt_we    = 1'b1;
              sctl.push = 1'b1;
            end
          end
          trq_pkg::OP_DECREMENT: begin
            if (slen != '0) begin
              k_nxt     = '0;
              state_nxt = S_DEC;
            end
          end
          trq_pkg::OP_WAKE: begin
            if (slen != '0) begin
              k_nxt     = trq_pkg::IDX_W'(slen - trq_pkg::LEN_W'(1));
              state_nxt = S_WAKE;
            end
          end
          default: ;
        endcase
      end
      S_DEC: begin
        // oldest to newest, one sleeper entry a cycle
        cnt_wa = trq_pkg::IDX_W'(kid);
        if (kcnt == '0) begin
          st_nxt = trq_pkg::ST_UNDERFLOW;
        end else begin
          cnt_we = 1'b1;
          cnt_wd = kcnt - trq_pkg::QUANTA_BITS'(1);
        end
        if (trq_pkg::LEN_W'(k_r) == slen - trq_pkg::LEN_W'(1)) begin
          state_nxt = S_OUT;
        end
        k_nxt = k_r + trq_pkg::IDX_W'(1);
      end
      S_WAKE: begin
        // newest to oldest; removal at k leaves lower entries in place
        if (kcnt == '0) begin
          if (32'(rlen) < trq_pkg::THREADS) begin
            rctl.push   = 1'b1;
            rctl.val    = kid;
            sctl.del_at = 1'b1;
            sctl.pos    = k_r;
          end else begin
            st_nxt = trq_pkg::ST_FULL;
          end
        end
        if (k_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          k_nxt = k_r - trq_pkg::IDX_W'(1);
        end
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          od_nxt    = {7'b0, slen, rlen, pop_r, st_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    op_r  <= op_nxt;
    id_r  <= id_nxt;
    q_r   <= q_nxt;
    k_r   <= k_nxt;
    st_r  <= st_nxt;
    pop_r <= pop_nxt;
    od_r  <= od_nxt;
    if (cnt_we) cnt_r[cnt_wa] <= cnt_wd;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

endmodule
